@@ sv/i2c_tbrf_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c_tbrf_pkg
// Shared types and constants of the i2c target block register file.
// ----------------------------------------------------------------------------
package i2c_tbrf_pkg;

  localparam int unsigned PtrW  = 9;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned CfgIdxW = 2;

  // transfer commands
  typedef enum logic [CmdW-1:0] {
    CMD_RX    = 3'd0,
    CMD_REQ   = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_LOAD  = 3'd3,
    CMD_FETCH = 3'd4
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_IS_INDEX = 2'd0,
    CFG_WRITE_LIMIT    = 2'd1,
    CFG_READ_LIMIT     = 2'd2
  } cfg_idx_e;

  // where the result byte comes from
  typedef enum logic [1:0] {
    RD_ZERO   = 2'd0,
    RD_RSTORE = 2'd1,
    RD_WSTORE = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic [PtrW-1:0] ptr_now;
    logic            taken;
    rd_src_e         rd_src;
  } ctrl_res_t;

endpackage

@@ sv/i2c_tbrf_store.sv @@
// ----------------------------------------------------------------------------
// i2c_tbrf_store
// Byte store with one write and one registered read port; entries never
// written read as zero.
// ----------------------------------------------------------------------------
module i2c_tbrf_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [7:0]       rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 8'h00;

endmodule

@@ sv/i2c_tbrf_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2c_tbrf_ctrl
// Pointer, first-byte and read-seen state; decodes one command per step and
// issues the store accesses.
// ----------------------------------------------------------------------------
module i2c_tbrf_ctrl
  import i2c_tbrf_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [7:0]       data_i,
  input  logic [7:0]       addr_i,
  input  logic             first_is_index_i,
  input  logic [7:0]       write_limit_i,
  input  logic [7:0]       read_limit_i,
  output ctrl_res_t        res_o,
  output logic             ws_we_o,
  output logic [AddrW-1:0] ws_waddr_o,
  output logic [AddrW-1:0] ws_raddr_o,
  output logic             rs_we_o,
  output logic [AddrW-1:0] rs_waddr_o,
  output logic [AddrW-1:0] rs_raddr_o
);

  localparam logic [PtrW-1:0] DepthP = PtrW'(Depth);

  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            await_q, await_d;
  logic            seen_q, seen_d;
  logic [PtrW-1:0] wlim, rlim;
  logic            addr_ok;
  logic            taken;
  rd_src_e         rd_src;

  // limits beyond the store act as the store size
  assign wlim = ({1'b0, write_limit_i} > DepthP) ? DepthP : {1'b0, write_limit_i};
  assign rlim = ({1'b0, read_limit_i} > DepthP) ? DepthP : {1'b0, read_limit_i};
  assign addr_ok = {1'b0, addr_i} < DepthP;

  always_comb begin
    ptr_d   = ptr_q;
    await_d = await_q;
    seen_d  = seen_q;
    taken   = 1'b0;
    rd_src  = RD_ZERO;
    ws_we_o = 1'b0;
    rs_we_o = 1'b0;
    unique case (cmd_i)
      CMD_RX: begin
        if (first_is_index_i && await_q) begin
          await_d = 1'b0;
          ptr_d   = {1'b0, data_i};
        end else if (ptr_q < wlim) begin
          ws_we_o = step_i;
          ptr_d   = ptr_q + 1'b1;
          taken   = 1'b1;
        end
      end
      CMD_REQ: begin
        seen_d = 1'b1;
        if (ptr_q < rlim) begin
          rd_src = RD_RSTORE;
          ptr_d  = ptr_q + 1'b1;
          taken  = 1'b1;
        end else begin
          ptr_d = rlim + 1'b1;
        end
      end
      CMD_STOP: begin
        if (first_is_index_i) begin
          // give back the prefetched byte
          if (seen_q && ptr_q != '0) begin
            ptr_d = ptr_q - 1'b1;
          end
        end else begin
          ptr_d = '0;
        end
        await_d = 1'b1;
        seen_d  = 1'b0;
      end
      CMD_LOAD: begin
        rs_we_o = step_i && addr_ok;
      end
      CMD_FETCH: begin
        if (addr_ok) begin
          rd_src = RD_WSTORE;
        end
      end
      default: begin
      end
    endcase
  end

  assign ws_waddr_o = ptr_q[AddrW-1:0];
  assign ws_raddr_o = addr_i[AddrW-1:0];
  assign rs_waddr_o = addr_i[AddrW-1:0];
  assign rs_raddr_o = ptr_q[AddrW-1:0];

  assign res_o.ptr_now = ptr_d;
  assign res_o.taken   = taken;
  assign res_o.rd_src  = rd_src;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      await_q <= 1'b1;
      seen_q  <= 1'b0;
    end else if (step_i) begin
      ptr_q   <= ptr_d;
      await_q <= await_d;
      seen_q  <= seen_d;
    end
  end

endmodule

@@ sv/i2c_target_block_register_file_core.sv @@
// ----------------------------------------------------------------------------
// i2c_target_block_register_file_core
// Byte-level data side of an i2c target: write store, read store and an
// auto-incrementing pointer.
// ----------------------------------------------------------------------------
// The input stream carries one command per transfer: a received bus byte, a
// requested bus byte, a stop, a host load into the read store or a host fetch
// from the write store. Every input transfer yields exactly one output
// transfer with the byte for the bus master or host, a taken flag and the
// pointer after the command.
// A transfer lands in an input register; when the output register can take
// it, the command is decoded, the pointer updated and both stores are written
// or read, and the result moves into the output register together with the
// registered store read. m_axis_tvalid comes from that output register, and
// one transfer per cycle is sustained while the output does not stall, since
// each store has its own write and read port.
// A stalled output holds its result; the input register keeps taking a new
// transfer until it is full as well, then tready drops.
// Reset clears the pointer, the read-seen flag, both pipeline stages and the
// per-entry valid bits of both stores, so every entry reads as zero until
// written, and sets the await-index flag. Configuration writes are registered
// from cfg_we_i and should only be issued while no transfer is in flight.
// ----------------------------------------------------------------------------
module i2c_target_block_register_file_core
  import i2c_tbrf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // command[2:0], data_byte[10:3], host_address[18:11], zero fill
  input  logic [23:0]        s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // read_data[7:0], byte_taken[8], pointer_now[17:9], zero fill
  output logic [23:0]        m_axis_tdata
);

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic       first_is_index_q;
  logic [7:0] write_limit_q;
  logic [7:0] read_limit_q;

  logic            a_valid_q;
  logic [CmdW-1:0] a_cmd_q;
  logic [7:0]      a_data_q;
  logic [7:0]      a_addr_q;
  logic            a_step;
  logic            b_ready;
  logic            b_valid_q;
  ctrl_res_t       b_res_q;
  ctrl_res_t       res;

  logic             ws_we, rs_we;
  logic [AddrW-1:0] ws_waddr, ws_raddr, rs_waddr, rs_raddr;
  logic [7:0]       ws_rdata, rs_rdata;
  logic [7:0]       rd_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_is_index_q <= 1'b1;
      write_limit_q    <= 8'h00;
      read_limit_q     <= 8'h00;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_IS_INDEX: first_is_index_q <= cfg_data_i[0];
        CFG_WRITE_LIMIT:    write_limit_q    <= cfg_data_i;
        CFG_READ_LIMIT:     read_limit_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign b_ready       = !b_valid_q || m_axis_tready;
  assign a_step        = a_valid_q && b_ready;
  assign s_axis_tready = !a_valid_q || b_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_cmd_q  <= s_axis_tdata[2:0];
      a_data_q <= s_axis_tdata[10:3];
      a_addr_q <= s_axis_tdata[18:11];
    end
  end

  i2c_tbrf_ctrl #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (a_step),
    .cmd_i            (a_cmd_q),
    .data_i           (a_data_q),
    .addr_i           (a_addr_q),
    .first_is_index_i (first_is_index_q),
    .write_limit_i    (write_limit_q),
    .read_limit_i     (read_limit_q),
    .res_o            (res),
    .ws_we_o          (ws_we),
    .ws_waddr_o       (ws_waddr),
    .ws_raddr_o       (ws_raddr),
    .rs_we_o          (rs_we),
    .rs_waddr_o       (rs_waddr),
    .rs_raddr_o       (rs_raddr)
  );

  i2c_tbrf_store #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_write_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ws_we),
    .waddr_i (ws_waddr),
    .wdata_i (a_data_q),
    .re_i    (a_step),
    .raddr_i (ws_raddr),
    .rdata_o (ws_rdata)
  );

  i2c_tbrf_store #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_read_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (a_data_q),
    .re_i    (a_step),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  // output register, store read data is registered inside the stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_step) begin
      b_res_q <= res;
    end
  end

  always_comb begin
    case (b_res_q.rd_src)
      RD_RSTORE: rd_byte = rs_rdata;
      RD_WSTORE: rd_byte = ws_rdata;
      default:   rd_byte = 8'h00;
    endcase
  end

  assign m_axis_tvalid = b_valid_q;
  assign m_axis_tdata  = {6'b0, b_res_q.ptr_now, b_res_q.taken, rd_byte};

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the i2c target block register file core. Bus
// transactions (index byte, data bytes, requests, stop) and host loads and
// fetches stream in with bursty timing while the output side stalls on its
// own pattern. A local predictor of pointer and stores computes every result,
// and each output transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import i2c_tbrf_pkg::*;

  // commands that the block has no use for
  localparam logic [CmdW-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam int unsigned MAX_REPORTS = 200;

  typedef struct packed {
    logic [ByteW-1:0] host_addr;
    logic [ByteW-1:0] data_byte;
    logic [CmdW-1:0]  command;
  } bus_cmd_t;

  typedef struct packed {
    logic [PtrW-1:0]  ptr_now;
    logic             taken;
    logic [ByteW-1:0] rd_byte;
  } bus_res_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = CFG_FIRST_IS_INDEX;
  logic [7:0]         cfg_data_i    = 8'h00;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata  = 24'h0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;

  i2c_target_block_register_file_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic             index_mode;
  logic [ByteW-1:0] wr_limit;
  logic [ByteW-1:0] rd_limit;
  logic [PtrW-1:0]  ptr;
  logic             awaiting_index;
  logic             read_since_stop;
  logic [ByteW-1:0] wr_mem [0:255];
  logic [ByteW-1:0] rd_mem [0:255];

  bus_res_t    pending_results[$];
  int unsigned errors     = 0;
  int unsigned burst_left = 0;
  logic [15:0] stall_cycle = '0;
  logic [1:0]  stall_mode  = '0;

  function automatic bus_res_t predict_bus_result(bus_cmd_t c);
    bus_res_t r = '0;
    case (c.command)
      CMD_RX: begin
        if (index_mode && awaiting_index) begin
          awaiting_index = 1'b0;
          ptr = {1'b0, c.data_byte};
        end else if (ptr < {1'b0, wr_limit}) begin
          wr_mem[ptr[ByteW-1:0]] = c.data_byte;
          ptr = ptr + 1'b1;
          r.taken = 1'b1;
        end
      end
      CMD_REQ: begin
        read_since_stop = 1'b1;
        if (ptr < {1'b0, rd_limit}) begin
          r.rd_byte = rd_mem[ptr[ByteW-1:0]];
          ptr = ptr + 1'b1;
          r.taken = 1'b1;
        end else begin
          // overrun parks one past the limit
          ptr = {1'b0, rd_limit} + 9'd1;
        end
      end
      CMD_STOP: begin
        if (index_mode) begin
          // give back the prefetched byte
          if (read_since_stop && ptr != '0) ptr = ptr - 1'b1;
        end else begin
          ptr = '0;
        end
        awaiting_index  = 1'b1;
        read_since_stop = 1'b0;
      end
      CMD_LOAD:  rd_mem[c.host_addr] = c.data_byte;
      CMD_FETCH: r.rd_byte = wr_mem[c.host_addr];
      default: ;
    endcase
    r.ptr_now = ptr;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
  endtask

  // predicts accepted inputs and checks accepted outputs
  always @(posedge clk_i) begin : monitor
    bus_res_t got;
    bus_res_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(predict_bus_result(bus_cmd_t'(s_axis_tdata[18:0])));
      if (m_axis_tvalid && m_axis_tready) begin
        got = bus_res_t'(m_axis_tdata[17:0]);
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", 0, int'(got));
        end else begin
          want = pending_results.pop_front();
          if (got.rd_byte !== want.rd_byte)
            note_mismatch("read_data", want.rd_byte, got.rd_byte);
          if (got.taken !== want.taken)
            note_mismatch("byte_taken", want.taken, got.taken);
          if (got.ptr_now !== want.ptr_now)
            note_mismatch("pointer_now", want.ptr_now, got.ptr_now);
        end
      end
    end
  end

  // receiver stalls, pattern picked anew whenever stall_cycle[5:0] is zero
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1'b1;
    if (stall_cycle[5:0] == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_cycle[2:0] < 3'd5);
    endcase
  end

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] dbyte,
                           input logic [ByteW-1:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, addr, dbyte, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_registers(input logic idx_mode, input logic [7:0] wlim,
                               input logic [7:0] rlim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FIRST_IS_INDEX;
    cfg_data_i <= {7'd0, idx_mode};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WRITE_LIMIT;
    cfg_data_i <= wlim;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_READ_LIMIT;
    cfg_data_i <= rlim;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    index_mode = idx_mode;
    wr_limit   = wlim;
    rd_limit   = rlim;
    @(posedge clk_i);
  endtask

  // pointer value biased toward the limit edges
  function automatic logic [7:0] pick_index(input logic [7:0] lim);
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return (lim >= 8'd3) ? lim - 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 3));
      2: return 8'($urandom_range(0, 15));
      default: return lim;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_item(CMD_REQ, 8'h00, 8'h00);        // read overrun at limit zero
    send_item(CMD_STOP, 8'h00, 8'h00);
    send_item(CMD_RX, 8'hFF, 8'h00);         // index byte
    send_item(CMD_RX, 8'hAA, 8'hFF);         // write overrun
    send_item(CMD_SPARE_LAST, 8'hFF, 8'hFF);
    send_item(CMD_STOP, 8'h00, 8'h00);
    wait_idle();
  endtask

  task automatic test_corner_cases();
    set_registers(1'b1, 8'hFF, 8'hFF);
    send_item(CMD_LOAD, 8'hFF, 8'hFF);
    send_item(CMD_LOAD, 8'h5A, 8'h00);
    send_item(CMD_RX, 8'hFE, 8'h00);
    send_item(CMD_RX, 8'h11, 8'h00);
    send_item(CMD_RX, 8'h22, 8'h00);         // dropped at the write limit
    send_item(CMD_FETCH, 8'h00, 8'hFE);
    send_item(CMD_FETCH, 8'h00, 8'hFF);
    send_item(CMD_STOP, 8'h00, 8'h00);       // no read, pointer kept
    send_item(CMD_RX, 8'hFE, 8'h00);
    send_item(CMD_REQ, 8'h00, 8'h00);
    send_item(CMD_REQ, 8'h00, 8'h00);        // parks at 256
    send_item(CMD_STOP, 8'h00, 8'h00);
    wait_idle();
    set_registers(1'b0, 8'd1, 8'd2);
    send_item(CMD_RX, 8'h00, 8'h00);
    send_item(CMD_STOP, 8'h00, 8'h00);
    send_item(CMD_RX, 8'h80, 8'h00);
    send_item(CMD_REQ, 8'h00, 8'h00);
    send_item(CMD_REQ, 8'h00, 8'h00);
    send_item(CMD_STOP, 8'h00, 8'h00);
    send_item(CMD_FETCH, 8'h00, 8'h00);
    send_item(CMD_SPARE_FIRST, 8'h00, 8'h00);
    wait_idle();
  endtask

  task automatic run_bus_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 8);
      if (kind <= 6) begin
        // one bus transaction: optional index byte, data or requests, optional stop
        if (index_mode && $urandom_range(0, 4) != 0) begin
          send_item(CMD_RX, pick_index(kind <= 3 ? wr_limit : rd_limit),
                    8'($urandom_range(0, 255)));
          sent++;
        end
        repeat (len) begin
          send_item(kind <= 3 ? CMD_RX : CMD_REQ, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
          sent++;
        end
        if ($urandom_range(0, 9) != 0) begin
          send_item(CMD_STOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          sent++;
        end
      end else if (kind <= 8) begin
        repeat (len) begin
          send_item(kind == 7 ? CMD_LOAD : CMD_FETCH, 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                      : pick_index(kind == 7 ? rd_limit : wr_limit));
          sent++;
        end
      end else begin
        repeat (len) begin
          send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  task automatic test_random_sessions();
    set_registers(1'b1, 8'hFF, 8'hFF);
    run_bus_traffic(260);
    set_registers(1'b0, 8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
    run_bus_traffic(240);
    set_registers(1'b1, 8'h00, 8'h00);
    run_bus_traffic(160);
    set_registers(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_bus_traffic(260);
    set_registers(1'b0, 8'hFF, 8'hFF);
    run_bus_traffic(240);
    set_registers(1'b1, 8'($urandom_range(1, 24)), 8'($urandom_range(1, 24)));
    run_bus_traffic(260);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      wr_mem[i] = '0;
      rd_mem[i] = '0;
    end
    index_mode      = 1'b1;
    wr_limit        = '0;
    rd_limit        = '0;
    ptr             = '0;
    awaiting_index  = 1'b1;
    read_since_stop = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_corner_cases();
    test_random_sessions();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
